// ----- design/assert_macros.svh -----
// Assertion macros used by the scheduler unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/ads_pkg.sv -----
// Types and codes of the autosave deadline scheduler.
`timescale 1ns / 1ps
package ads_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int MAX_RESULTS   = 16;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_TRIG   = 3'd3;
    localparam logic [2:0] ACT_MARK   = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    localparam logic [2:0] EV_CHECKED = 3'd0;
    localparam logic [2:0] EV_SAVE    = 3'd1;
    localparam logic [2:0] EV_BACKUP  = 3'd2;
    localparam logic [2:0] EV_NONE    = 3'd3;
    localparam logic [2:0] EV_ABSENT  = 3'd4;
    localparam logic [2:0] EV_PRESENT = 3'd5;
    localparam logic [2:0] EV_ACK     = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [47:0] now_time;
        logic [31:0] check_interval;
        logic [31:0] backup_interval;
    } t_in_item;

    typedef struct packed {
        logic [3:0] slot_out;
        logic [2:0] event_res;
        logic       last;
    } t_out_item;

endpackage

// ----- design/autosave_deadline_scheduler_unit.sv -----
// Autosave deadline scheduler: slot table, deadline scan and shared saturating adder.
// Remove, mark, clear and add answer from S_DECODE; trigger goes on through S_RD, S_H1, S_H2, S_H3.
// A tick runs one full scan of the slot memory per result, plus a closing scan that finds
// nothing due, skipped once the results reach MAX_RESULTS; a scan reads one entry a cycle.
// One transaction at a time: busy falls as the last result shows; results cannot be stalled.
// Reset (synchronous, active low) clears active and changed marks; times stay unset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module autosave_deadline_scheduler_unit #(
    parameter int SLOTS     = ads_pkg::SLOTS_DEF,
    parameter int TIME_BITS = ads_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ads_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_res_valid,
    output ads_pkg::t_out_item o_res
);
    import ads_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);
    localparam logic [TIME_BITS-1:0] NEVER = '1;

    typedef struct packed {
        logic [TIME_BITS-1:0] dl;
        logic [TIME_BITS-1:0] chk;
        logic [TIME_BITS-1:0] bak;
        logic [31:0]          cp;
        logic [31:0]          bd;
    } t_entry;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_SCAN_END = 8'b0000_1000,
        S_RD       = 8'b0001_0000,
        S_H1       = 8'b0010_0000,
        S_H2       = 8'b0100_0000,
        S_H3       = 8'b1000_0000
    } t_state;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [31:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        if (s >= {1'b0, NEVER}) begin
            return NEVER - TIME_BITS'(1);
        end
        return s[TIME_BITS-1:0];
    endfunction

    t_state               r_state, n_state;
    t_in_item             r_item, n_item;
    logic [SLOTS-1:0]     r_active, n_active;
    logic [SLOTS-1:0]     r_changed, n_changed;
    logic [SLOTS-1:0]     r_done, n_done;
    logic [CW-1:0]        r_scan, n_scan;
    logic                 r_tag_v, n_tag_v;
    logic [IW-1:0]        r_tag, n_tag;
    logic                 r_found, n_found;
    logic [IW-1:0]        r_best, n_best;
    logic [TIME_BITS-1:0] r_bt, n_bt;
    logic [IW-1:0]        r_sel, n_sel;
    logic                 r_force, n_force;
    logic [2:0]           r_ev, n_ev;
    logic [TIME_BITS-1:0] r_nbak, n_nbak;
    logic [TIME_BITS-1:0] r_nchk, n_nchk;
    logic [RW-1:0]        r_cnt, n_cnt;
    logic                 r_pend_v, n_pend_v;
    logic [IW-1:0]        r_pend_slot, n_pend_slot;
    logic [2:0]           r_pend_ev, n_pend_ev;
    logic                 r_out_v, n_out_v;
    t_out_item            r_out, n_out;

    t_entry               r_mem [SLOTS];
    t_entry               r_rd;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [IW-1:0]        mem_raddr;
    t_entry               mem_wdata;

    logic [TIME_BITS-1:0] now_t;
    logic [31:0]          ci_fix;
    logic [31:0]          bi_fix;
    logic [31:0]          su_b;
    logic [TIME_BITS-1:0] su_out;
    logic                 slot_ok;
    logic [IW-1:0]        sel_idx;
    logic                 present;
    logic                 due_chk;

    assign now_t   = TIME_BITS'(r_item.now_time);
    assign ci_fix  = (r_item.check_interval == 32'd0) ? 32'd1 : r_item.check_interval;
    assign bi_fix  = (r_item.backup_interval == 32'd0) ? 32'd1 : r_item.backup_interval;
    assign slot_ok = 8'(r_item.slot) < 8'(SLOTS);
    assign sel_idx = IW'(r_item.slot);
    assign present = slot_ok && r_active[sel_idx];
    assign due_chk = r_force || (now_t >= r_rd.chk);

    // The one saturating adder, shared by add, backup re-arm and check re-arm.
    always_comb begin
        case (r_state)
            S_H1:    su_b = r_rd.bd;
            S_H2:    su_b = r_rd.cp;
            default: su_b = ci_fix;
        endcase
    end
    assign su_out = sat_add(now_t, su_b);

    assign mem_raddr = (r_state == S_SCAN) ? r_scan[IW-1:0] : r_sel;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_active    = r_active;
        n_changed   = r_changed;
        n_done      = r_done;
        n_scan      = r_scan;
        n_tag_v     = 1'b0;
        n_tag       = r_scan[IW-1:0];
        n_found     = r_found;
        n_best      = r_best;
        n_bt        = r_bt;
        n_sel       = r_sel;
        n_force     = r_force;
        n_ev        = r_ev;
        n_nbak      = r_nbak;
        n_nchk      = r_nchk;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_ev   = r_pend_ev;
        n_out_v     = 1'b0;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_sel;
        mem_wdata   = r_rd;

        // Compare stage of the scan: the entry read last cycle against the best so far.
        if (r_tag_v && (r_rd.dl <= now_t) && (!r_found || (r_rd.dl < r_bt))) begin
            n_found = 1'b1;
            n_best  = r_tag;
            n_bt    = r_rd.dl;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                n_out   = '{slot_out: r_item.slot, event_res: EV_ACK, last: 1'b1};
                case (r_item.action)
                    ACT_TICK: begin
                        n_done   = '0;
                        n_cnt    = '0;
                        n_pend_v = 1'b0;
                        n_scan   = '0;
                        n_found  = 1'b0;
                        n_force  = 1'b0;
                        n_state  = S_SCAN;
                    end
                    ACT_CLEAR: begin
                        n_active          = '0;
                        n_out_v           = 1'b1;
                        n_out.slot_out    = 4'd0;
                    end
                    ACT_ADD: begin
                        n_out_v = 1'b1;
                        if (!slot_ok) begin
                            n_out.event_res = EV_ABSENT;
                        end else if (present) begin
                            n_out.event_res = EV_PRESENT;
                        end else begin
                            n_active[sel_idx]  = 1'b1;
                            n_changed[sel_idx] = 1'b0;
                            mem_we             = 1'b1;
                            mem_waddr          = sel_idx;
                            mem_wdata          = '{dl: su_out, chk: su_out, bak: NEVER,
                                                   cp: ci_fix, bd: bi_fix};
                        end
                    end
                    ACT_REMOVE: begin
                        n_out_v = 1'b1;
                        if (!present) begin
                            n_out.event_res = EV_ABSENT;
                        end else begin
                            n_active[sel_idx] = 1'b0;
                        end
                    end
                    ACT_MARK: begin
                        n_out_v = 1'b1;
                        if (!present) begin
                            n_out.event_res = EV_ABSENT;
                        end else begin
                            n_changed[sel_idx] = 1'b1;
                        end
                    end
                    ACT_TRIG: begin
                        if (!present) begin
                            n_out_v         = 1'b1;
                            n_out.event_res = EV_ABSENT;
                        end else begin
                            n_sel   = sel_idx;
                            n_force = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_scan == CW'(SLOTS)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_tag_v = r_active[r_scan[IW-1:0]] && !r_done[r_scan[IW-1:0]];
                    n_scan  = r_scan + CW'(1);
                end
            end
            S_SCAN_END: begin
                if (r_found) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = '{slot_out: 4'(r_pend_slot), event_res: r_pend_ev,
                                    last: 1'b0};
                    end
                    n_sel   = r_best;
                    n_state = S_RD;
                end else begin
                    // Nothing more is due: close the tick with the held result, or with EV_NONE if none is held.
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out = '{slot_out: 4'(r_pend_slot), event_res: r_pend_ev,
                                  last: 1'b1};
                    end else begin
                        n_out = '{slot_out: 4'd0, event_res: EV_NONE, last: 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_H1;
            end
            S_H1: begin
                if (due_chk && r_changed[r_sel]) begin
                    n_ev             = EV_SAVE;
                    n_changed[r_sel] = 1'b0;
                    n_nbak           = su_out;
                end else if (now_t >= r_rd.bak) begin
                    n_ev   = EV_BACKUP;
                    n_nbak = NEVER;
                end else begin
                    n_ev   = EV_CHECKED;
                    n_nbak = r_rd.bak;
                end
                n_state = S_H2;
            end
            S_H2: begin
                n_nchk  = su_out;
                n_state = S_H3;
            end
            S_H3: begin
                mem_we    = 1'b1;
                mem_waddr = r_sel;
                mem_wdata = '{dl: (r_nchk < r_nbak) ? r_nchk : r_nbak, chk: r_nchk,
                              bak: r_nbak, cp: r_rd.cp, bd: r_rd.bd};
                if (r_item.action == ACT_TICK) begin
                    n_done[r_sel] = 1'b1;
                    n_cnt         = r_cnt + RW'(1);
                    if (r_cnt == RW'(MAX_RESULTS - 1)) begin
                        n_out_v  = 1'b1;
                        n_out    = '{slot_out: 4'(r_sel), event_res: r_ev, last: 1'b1};
                        n_pend_v = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        // Hold the result until the next scan tells whether it is the last.
                        n_pend_v    = 1'b1;
                        n_pend_slot = r_sel;
                        n_pend_ev   = r_ev;
                        n_scan      = '0;
                        n_found     = 1'b0;
                        n_state     = S_SCAN;
                    end
                end else begin
                    n_out_v = 1'b1;
                    n_out   = '{slot_out: 4'(r_sel), event_res: r_ev, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_changed <= '0;
            r_done    <= '0;
            r_tag_v   <= 1'b0;
            r_found   <= 1'b0;
            r_cnt     <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_force   <= 1'b0;
            r_scan    <= '0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_changed <= n_changed;
            r_done    <= n_done;
            r_tag_v   <= n_tag_v;
            r_found   <= n_found;
            r_cnt     <= n_cnt;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
            r_force   <= n_force;
            r_scan    <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_tag       <= n_tag;
        r_best      <= n_best;
        r_bt        <= n_bt;
        r_sel       <= n_sel;
        r_ev        <= n_ev;
        r_nbak      <= n_nbak;
        r_nchk      <= n_nchk;
        r_pend_slot <= n_pend_slot;
        r_pend_ev   <= n_pend_ev;
        r_out       <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    `ASSERT_IMPLIES(a_res_after_busy, o_res_valid, $past(busy))
    `ASSERT_IMPLIES(a_last_frees, o_res_valid && o_res.last, !busy)
    `ASSERT_ALWAYS(a_cnt_bound, r_cnt <= RW'(MAX_RESULTS))

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the autosave deadline scheduler unit.
`timescale 1ns / 1ps
module testbench;
    import ads_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [47:0] NEVER = '1;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        t_in_item cmd;
        bit       settle;
    } t_queued_cmd;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_res_valid;
    t_out_item o_res;

    t_queued_cmd cmd_queue[$];
    t_out_item   expected_events[$];

    // Shadow copy of the slot table.
    bit          slot_on[SLOTS];
    bit          slot_dirty[SLOTS];
    logic [47:0] check_at[SLOTS];
    logic [47:0] backup_at[SLOTS];
    logic [31:0] check_every[SLOTS];
    logic [31:0] backup_after[SLOTS];

    int errors = 0;
    int sent_count = 0;
    int result_count = 0;
    int save_count = 0;
    int backup_count = 0;
    int full_ticks = 0;
    int burst_left = 8;
    int gap_left = 0;

    autosave_deadline_scheduler_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [47:0] clamp_sum(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        if (s >= {1'b0, NEVER}) begin
            return NEVER - 48'd1;
        end
        return s[47:0];
    endfunction

    function automatic logic [2:0] service_slot(int idx, logic [47:0] now, bit forced);
        logic [2:0] ev;
        ev = EV_CHECKED;
        if ((forced || now >= check_at[idx]) && slot_dirty[idx]) begin
            ev = EV_SAVE;
            slot_dirty[idx] = 1'b0;
            backup_at[idx] = clamp_sum(now, backup_after[idx]);
            save_count++;
        end else if (now >= backup_at[idx]) begin
            ev = EV_BACKUP;
            backup_at[idx] = NEVER;
            backup_count++;
        end
        check_at[idx] = clamp_sum(now, check_every[idx]);
        return ev;
    endfunction

    task automatic predict_results(input t_in_item cmd);
        t_out_item   batch[$];
        t_out_item   res;
        bit          handled[SLOTS];
        bit          emit;
        int          pick;
        int          idx;
        int          i;
        logic [47:0] pick_time;
        logic [47:0] due;
        logic [47:0] now;
        now = cmd.now_time;
        idx = cmd.slot;
        emit = 1'b1;
        res.slot_out = cmd.slot;
        res.event_res = EV_ACK;
        res.last = 1'b1;
        case (cmd.action)
            ACT_TICK: begin
                emit = 1'b0;
                for (i = 0; i < SLOTS; i++) handled[i] = 1'b0;
                while (batch.size() < MAX_RESULTS) begin
                    pick = -1;
                    pick_time = '0;
                    for (i = 0; i < SLOTS; i++) begin
                        due = (check_at[i] < backup_at[i]) ? check_at[i] : backup_at[i];
                        if (slot_on[i] && !handled[i] && due <= now &&
                            (pick < 0 || due < pick_time)) begin
                            pick = i;
                            pick_time = due;
                        end
                    end
                    if (pick < 0) break;
                    handled[pick] = 1'b1;
                    res.slot_out = 4'(pick);
                    res.event_res = service_slot(pick, now, 1'b0);
                    res.last = 1'b0;
                    batch = {batch, res};
                end
                if (batch.size() == 0) begin
                    res.slot_out = 4'd0;
                    res.event_res = EV_NONE;
                    res.last = 1'b1;
                    batch = {batch, res};
                end else begin
                    batch[batch.size() - 1].last = 1'b1;
                    if (batch.size() == SLOTS) full_ticks++;
                end
                foreach (batch[k]) expected_events = {expected_events, batch[k]};
            end
            ACT_CLEAR: begin
                for (i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
                res.slot_out = 4'd0;
            end
            ACT_ADD: begin
                if (slot_on[idx]) begin
                    res.event_res = EV_PRESENT;
                end else begin
                    slot_on[idx] = 1'b1;
                    slot_dirty[idx] = 1'b0;
                    check_every[idx] = (cmd.check_interval == 0) ? 32'd1 : cmd.check_interval;
                    backup_after[idx] = (cmd.backup_interval == 0) ? 32'd1 : cmd.backup_interval;
                    check_at[idx] = clamp_sum(now, check_every[idx]);
                    backup_at[idx] = NEVER;
                end
            end
            ACT_REMOVE, ACT_TRIG, ACT_MARK: begin
                if (!slot_on[idx]) begin
                    res.event_res = EV_ABSENT;
                end else if (cmd.action == ACT_REMOVE) begin
                    slot_on[idx] = 1'b0;
                end else if (cmd.action == ACT_TRIG) begin
                    res.event_res = service_slot(idx, now, 1'b1);
                end else begin
                    slot_dirty[idx] = 1'b1;
                end
            end
            default: emit = 1'b0;
        endcase
        if (emit) expected_events = {expected_events, res};
    endtask

    task automatic queue_cmd(logic [2:0] act, int slot, logic [47:0] now,
                             logic [31:0] ci, logic [31:0] bi, bit settle = 1'b0);
        t_queued_cmd q;
        q.cmd.action = act;
        q.cmd.slot = 4'(slot);
        q.cmd.now_time = now;
        q.cmd.check_interval = ci;
        q.cmd.backup_interval = bi;
        q.settle = settle;
        cmd_queue = {cmd_queue, q};
    endtask

    function automatic logic [31:0] pick_interval(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'd0;
        if (r < 12) return 32'($urandom);
        return 32'($urandom_range(1, span));
    endfunction

    function automatic logic [47:0] rand_time();
        logic [47:0] t;
        t = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
        if (t == NEVER) t = NEVER - 48'd1;
        return t;
    endfunction

    // Starts from an empty table, fills every slot, then runs a random mix of commands
    // on a clock that mostly moves forward in small steps.
    task automatic random_epoch(logic [47:0] base, int count);
        logic [47:0] clock_ms;
        int          step;
        int          r;
        int          s;
        int          k;
        clock_ms = base;
        queue_cmd(ACT_CLEAR, 0, clock_ms, $urandom, $urandom, 1'b1);
        for (s = 0; s < SLOTS; s++) begin
            queue_cmd(ACT_ADD, s, clock_ms, pick_interval(40), pick_interval(60));
        end
        for (s = 0; s < SLOTS; s++) begin
            if ($urandom_range(0, 1)) queue_cmd(ACT_MARK, s, clock_ms, $urandom, $urandom);
        end
        for (k = 0; k < count; k++) begin
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 25);
            if (clock_ms > NEVER - 48'd1 - 48'(step)) begin
                clock_ms = NEVER - 48'd1;
            end else begin
                clock_ms = clock_ms + 48'(step);
            end
            s = $urandom_range(0, SLOTS - 1);
            r = $urandom_range(0, 99);
            if (r < 36) begin
                queue_cmd(ACT_TICK, s, clock_ms, $urandom, $urandom);
            end else if (r < 52) begin
                queue_cmd(ACT_MARK, s, clock_ms, $urandom, $urandom);
            end else if (r < 64) begin
                queue_cmd(ACT_TRIG, s, clock_ms, $urandom, $urandom);
            end else if (r < 76) begin
                queue_cmd(ACT_ADD, s, clock_ms, pick_interval(40), pick_interval(60));
            end else if (r < 84) begin
                queue_cmd(ACT_REMOVE, s, clock_ms, $urandom, $urandom);
            end else if (r < 87) begin
                queue_cmd(ACT_CLEAR, s, clock_ms, $urandom, $urandom);
            end else if (r < 90) begin
                queue_cmd($urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7, s, rand_time(),
                          $urandom, $urandom);
            end else begin
                queue_cmd(3'($urandom_range(0, 5)), s, rand_time(), $urandom, $urandom);
            end
        end
    endtask

    // Driver: presents queued commands in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_results(i_item);
                sent_count++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 12);
                    case ($urandom_range(0, 9))
                        0, 1: gap_left = 0;
                        2, 3, 4, 5, 6: gap_left = $urandom_range(1, 6);
                        7, 8: gap_left = $urandom_range(10, 60);
                        default: gap_left = $urandom_range(100, 400);
                    endcase
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             (!cmd_queue[0].settle || (expected_events.size() == 0 && !busy))) begin
                    i_item <= cmd_queue[0].cmd;
                    start <= 1'b1;
                    void'(cmd_queue.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_valid !== 1'b0) begin
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: slot %0d event %0d last %0b",
                         $time, o_res.slot_out, o_res.event_res, o_res.last);
            end else begin
                want = expected_events.pop_front();
                result_count++;
                if (o_res.slot_out !== want.slot_out) begin
                    errors++;
                    $display("%0t: slot_out expected %0d actual %0d",
                             $time, want.slot_out, o_res.slot_out);
                end
                if (o_res.event_res !== want.event_res) begin
                    errors++;
                    $display("%0t: event_res expected %0d actual %0d (slot %0d)",
                             $time, want.event_res, o_res.event_res, want.slot_out);
                end
                if (o_res.last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b (slot %0d)",
                             $time, want.last, o_res.last, want.slot_out);
                end
            end
        end
    end

    initial begin
        // Empty table, then commands on slots that are not present.
        queue_cmd(ACT_TICK, 0, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_REMOVE, 3, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_TRIG, 3, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_MARK, 3, 48'd0, 32'd0, 32'd0);
        // Zero intervals are taken as one; a second add finds the slot present.
        queue_cmd(ACT_ADD, 0, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_ADD, 0, 48'd0, 32'd5, 32'd5);
        queue_cmd(ACT_ADD, 15, 48'd0, '1, '1);
        queue_cmd(ACT_ADD, 5, 48'd0, 32'd10, 32'd5);
        queue_cmd(ACT_MARK, 5, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_MARK, 0, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_TICK, 0, 48'd1, 32'd0, 32'd0);
        queue_cmd(ACT_TICK, 0, 48'd10, 32'd0, 32'd0);
        queue_cmd(ACT_TRIG, 15, 48'd20, 32'd0, 32'd0);
        queue_cmd(ACT_MARK, 15, 48'd20, 32'd0, 32'd0);
        queue_cmd(ACT_TRIG, 15, 48'd21, 32'd0, 32'd0);
        // Two slots sharing a deadline: the lower slot goes first.
        queue_cmd(ACT_ADD, 9, 48'd100, 32'd50, 32'd7);
        queue_cmd(ACT_ADD, 8, 48'd100, 32'd50, 32'd7);
        queue_cmd(ACT_TICK, 0, 48'd150, 32'd0, 32'd0);
        // Sums near the top of the time range saturate below never.
        queue_cmd(ACT_ADD, 7, NEVER - 48'd1, '1, '1);
        queue_cmd(ACT_MARK, 7, NEVER - 48'd1, '1, '1);
        queue_cmd(ACT_TICK, 0, NEVER - 48'd1, '1, '1);
        queue_cmd(ACT_RSVD6, 2, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_RSVD7, 2, NEVER - 48'd1, '1, '1);
        queue_cmd(ACT_REMOVE, 5, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_CLEAR, 0, 48'd0, 32'd0, 32'd0);
        queue_cmd(ACT_TICK, 0, NEVER - 48'd1, 32'd0, 32'd0);

        random_epoch(48'd0, 75);
        random_epoch(rand_time() >> 1, 75);
        random_epoch(NEVER - 48'd5000, 75);
        random_epoch(rand_time(), 75);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || expected_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Ran %0d transactions, checked %0d results: %0d saves, %0d backup saves,",
                 sent_count, result_count, save_count, backup_count);
        $display("%0d ticks serviced the whole table; %0d mismatches.", full_ticks, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d commands queued and %0d results outstanding.",
                 cmd_queue.size(), expected_events.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
